// ===== rtl/xsave_feature_locator_core_assert.svh =====
// Assertion macros for the feature locator.
`ifndef XSAVE_FEATURE_LOCATOR_CORE_ASSERT_SVH
`define XSAVE_FEATURE_LOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define XFL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define XFL_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define XFL_ASSERT(label, clk, rst, prop, msg)
`define XFL_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/xfl_pkg.sv =====
package xfl_pkg;

  localparam int NumFeatures = 64;
  localparam int IdWidth = 6;
  localparam int QueueDepth = 2;

  localparam logic [31:0] LegacyBytes = 32'd512;
  localparam logic [31:0] CompactBase = 32'd576;
  localparam logic [31:0] AllowedFlags = 32'd7;
  localparam int CompactFlagBit = 1;
  localparam logic [IdWidth-1:0] FirstExtFeature = 6'd2;

  localparam logic [1:0] RegEnabled = 2'd0;
  localparam logic [1:0] RegSupervisor = 2'd1;
  localparam logic [1:0] RegAligned = 2'd2;
  localparam logic [1:0] RegFlags = 2'd3;

  localparam logic OpWrite = 1'b0;
  localparam logic OpLocate = 1'b1;

  // Classified work handed from front to back.
  typedef struct packed {
    logic                is_write;
    logic                pass;     // all checks passed
    logic                compact;
    logic                present;  // feature in compaction mask
    logic [IdWidth-1:0]  id;
    logic [31:0]         std_offset;
    logic [31:0]         std_size;
    logic [31:0]         compact_size;
    logic [31:0]         xstate_offset;
    logic [63:0]         compaction_mask;
    logic [63:0]         aligned;
  } job_t;

  function automatic logic [31:0] align64(input logic [31:0] v);
    logic [31:0] s;
    s = v + 32'd63;
    return {s[31:6], 6'd0};
  endfunction

endpackage

// ===== rtl/xfl_front.sv =====
module xfl_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                operation,
  input  logic [5:0]          feature_id,
  input  logic [31:0]         entry_std_offset,
  input  logic [31:0]         entry_std_size,
  input  logic [31:0]         entry_compact_size,
  input  logic [31:0]         all_offset,
  input  logic [31:0]         all_length,
  input  logic [31:0]         xstate_offset,
  input  logic [31:0]         xstate_length,
  input  logic [63:0]         compaction_mask,
  input  logic [63:0]         enabled_features,
  input  logic [63:0]         supervisor_visible_features,
  input  logic [63:0]         aligned_features,
  input  logic [31:0]         control_flags,
  output logic                job_valid,
  input  logic                job_take,
  output xfl_pkg::job_t       job
);

  xfl_pkg::job_t q [xfl_pkg::QueueDepth];
  logic [0:0] wr_ptr, rd_ptr;
  logic [1:0] count;
  logic accept;
  logic id_ok, en_ok, flag_ok, bnd_ok;
  logic [31:0] all_end, xs_end;
  xfl_pkg::job_t cls;

  assign full = (count == 2'(xfl_pkg::QueueDepth));
  assign accept = push && !full;
  assign job_valid = (count != 2'd0);
  assign job = q[rd_ptr];

  always_comb begin
    all_end = all_offset + all_length;
    xs_end = xstate_offset + xstate_length;
    id_ok = feature_id >= xfl_pkg::FirstExtFeature;
    en_ok = |((enabled_features | supervisor_visible_features) & (64'd1 << feature_id));
    flag_ok = (control_flags & ~xfl_pkg::AllowedFlags) == 32'd0;
    bnd_ok = !(all_offset > xstate_offset) && !(all_end < xs_end);
    cls.is_write = (operation == xfl_pkg::OpWrite);
    cls.pass = id_ok && en_ok && flag_ok && bnd_ok;
    cls.compact = control_flags[xfl_pkg::CompactFlagBit];
    cls.present = compaction_mask[feature_id];
    cls.id = feature_id;
    cls.std_offset = entry_std_offset;
    cls.std_size = entry_std_size;
    cls.compact_size = entry_compact_size;
    cls.xstate_offset = xstate_offset;
    cls.compaction_mask = compaction_mask;
    cls.aligned = aligned_features;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + 1'b1;
      if (job_take) rd_ptr <= rd_ptr + 1'b1;
      count <= count + 2'(accept) - 2'(job_take);
    end
  end

endmodule

// ===== rtl/xfl_back.sv =====
`include "xsave_feature_locator_core_assert.svh"
module xfl_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_take,
  input  xfl_pkg::job_t       job,
  output logic                empty,
  input  logic                pop,
  output logic                found,
  output logic                length_valid,
  output logic [31:0]         feature_offset,
  output logic [31:0]         feature_length
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_WALK  = 5'b00100,
    S_FIN   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state, state_next;
  xfl_pkg::job_t cur;
  logic [31:0] off_mem [xfl_pkg::NumFeatures];
  logic [31:0] ssz_mem [xfl_pkg::NumFeatures];
  logic [31:0] csz_mem [xfl_pkg::NumFeatures];
  logic [31:0] rd_off, rd_ssz, rd_csz, walk_csz;
  logic [5:0] j, j_prev;
  logic walk_live;
  logic [31:0] base, stepped;
  logic out_full;

  assign empty = !out_full;
  assign job_take = (state == S_IDLE) && job_valid;

  // Table write port and lookups; read data registered.
  always_ff @(posedge clk) begin
    if (job_take && job.is_write) begin
      off_mem[job.id] <= job.std_offset;
      ssz_mem[job.id] <= job.std_size;
      csz_mem[job.id] <= job.compact_size;
    end
    if (state == S_IDLE) begin
      rd_off <= off_mem[job.id];
      rd_ssz <= ssz_mem[job.id];
      rd_csz <= csz_mem[job.id];
    end
    walk_csz <= csz_mem[j];
  end

  always_comb begin
    stepped = base;
    if (cur.compaction_mask[j_prev]) begin
      if (cur.aligned[j_prev]) stepped = xfl_pkg::align64(base);
      stepped = stepped + walk_csz;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (job_take && !job.is_write) state_next = S_READ;
      S_READ: begin
        if (cur.pass && cur.compact && cur.present && cur.id > xfl_pkg::FirstExtFeature)
          state_next = S_WALK;
        else
          state_next = S_FIN;
      end
      S_WALK: if (!walk_live && j_prev == cur.id - 6'd1) state_next = S_FIN;
      S_FIN: state_next = S_OUT;
      S_OUT: if (pop) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN) out_full <= 1'b1;
      else if (pop && out_full) out_full <= 1'b0;
    end
  end

  // Walk: j addresses the table, j_prev is the entry whose data is now valid.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (job_take) cur <= job;
      S_READ: begin
        base <= xfl_pkg::CompactBase;
        j <= xfl_pkg::FirstExtFeature;
        walk_live <= 1'b1;
      end
      S_WALK: begin
        if (walk_live) begin
          walk_live <= 1'b0;
          j_prev <= j;
          j <= j + 6'd1;
        end else begin
          base <= stepped;
          j_prev <= j;
          j <= j + 6'd1;
        end
      end
      S_FIN: begin
        found <= 1'b0;
        length_valid <= 1'b0;
        feature_offset <= 32'd0;
        feature_length <= 32'd0;
        if (cur.pass) begin
          length_valid <= 1'b1;
          feature_length <= cur.compact ? rd_csz : rd_ssz;
          if (!cur.compact) begin
            found <= 1'b1;
            feature_offset <= cur.xstate_offset + rd_off - xfl_pkg::LegacyBytes;
          end else if (cur.present) begin
            found <= 1'b1;
            feature_offset <= cur.xstate_offset - xfl_pkg::LegacyBytes +
              (cur.aligned[cur.id] ? xfl_pkg::align64(base) : base);
          end
        end
      end
      default: ;
    endcase
  end

  `XFL_ASSERT(a_out_only_done, clk, rst, !empty |-> state == S_OUT, "result shown outside output state")
  `XFL_ASSERT(a_found_len, clk, rst, (!empty && found) |-> length_valid, "found without length")
  `XFL_ASSERT(a_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(feature_offset)), "result dropped")
  `XFL_ASSERT_NR(a_reset, clk, rst |=> empty, "result after reset")

endmodule

// ===== rtl/xsave_feature_locator_core.sv =====
// Table write: taken by the back end when idle, no result.
// Locate: the back end reads the table, then, for a compacted feature that passes the checks, is present
// and has id above 2, walks the compacted entries; it then registers the result and shows it until pop.
// The back end handles one locate at a time and takes no new job until its result is popped.
// Synchronous active-high rst clears config registers, state and queue pointers; the feature table is not cleared.
module xsave_feature_locator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        operation,
  input  logic [5:0]  feature_id,
  input  logic [31:0] entry_std_offset,
  input  logic [31:0] entry_std_size,
  input  logic [31:0] entry_compact_size,
  input  logic [31:0] all_offset,
  input  logic [31:0] all_length,
  input  logic [31:0] xstate_offset,
  input  logic [31:0] xstate_length,
  input  logic [63:0] compaction_mask,
  output logic        empty,
  input  logic        pop,
  output logic        found,
  output logic        length_valid,
  output logic [31:0] feature_offset,
  output logic [31:0] feature_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] enabled_features, supervisor_visible_features, aligned_features;
  logic [31:0] control_flags;
  logic job_valid, job_take;
  xfl_pkg::job_t job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_features <= 64'd0;
      supervisor_visible_features <= 64'd0;
      aligned_features <= 64'd0;
      control_flags <= 32'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        xfl_pkg::RegEnabled: enabled_features <= cfg_data;
        xfl_pkg::RegSupervisor: supervisor_visible_features <= cfg_data;
        xfl_pkg::RegAligned: aligned_features <= cfg_data;
        xfl_pkg::RegFlags: control_flags <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  xfl_front u_front (
    .clk, .rst, .push, .full, .operation, .feature_id, .entry_std_offset,
    .entry_std_size, .entry_compact_size, .all_offset, .all_length,
    .xstate_offset, .xstate_length, .compaction_mask, .enabled_features,
    .supervisor_visible_features, .aligned_features, .control_flags,
    .job_valid, .job_take, .job
  );

  xfl_back u_back (
    .clk, .rst, .job_valid, .job_take, .job, .empty, .pop, .found,
    .length_valid, .feature_offset, .feature_length
  );

endmodule
